### hw/rtl/fde_pkg.sv
// ----------------------------------------------------------------------------
// fde_pkg: shared constants for the feedback delay echo
// Register indexes, gain limits and the reciprocal used to divide by 1000.
// ----------------------------------------------------------------------------
package fde_pkg;

    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_MIX        = 2'd0;
    localparam t_reg_idx REG_FEEDBACK   = 2'd1;
    localparam t_reg_idx REG_DELAY_LEN  = 2'd2;
    localparam t_reg_idx REG_QUIET_LEN  = 2'd3;

    localparam int CFG_DATA_W = 17;

    localparam logic [15:0] MIX_RESET   = 16'd16384;
    localparam logic [9:0]  FB_RESET    = 10'd0;
    localparam logic [16:0] DELAY_RESET = 17'd4410;
    localparam logic [15:0] QUIET_RESET = 16'd0;

    localparam logic [16:0] MIX_ONE     = 17'd32768;
    localparam logic [9:0]  FB_LIMIT    = 10'd900;
    localparam logic signed [15:0] QUIET_LEVEL = 16'sd22;
    localparam logic [16:0] QUIET_MAX   = 17'h1FFFF;

    // floor(p / 1000) == (p * FB_RECIP) >> FB_RECIP_SHIFT for all p < 2**25
    localparam logic [25:0] FB_RECIP       = 26'd34359739;
    localparam int          FB_RECIP_SHIFT = 35;

endpackage

### hw/rtl/feedback_delay_echo.sv
// ----------------------------------------------------------------------------
// feedback_delay_echo: echo effect over a circular delay line
// Mixes each sample with its delayed copy and writes input plus feedback back
// into the line; tail items drain the line and flag when it has gone quiet.
// ----------------------------------------------------------------------------
// One item per clock while delay_length is 3 or more and the output does
// not stall. Each item makes one read-modify-write of the delay memory
// through a four-stage pipe (read, multiply, reciprocal divide, write back);
// an item whose entry is still in the multiply or divide stage waits, so a
// length of 1 or 2 holds each item until the one before on its entry writes
// back. The memory needs no clearing after reset: a fill mark makes entries
// not yet written read as zero. Results leave through an output register.
module feedback_delay_echo #(
    parameter int MAX_DELAY = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    // input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] sample_in
    input  logic        i_s_axis_tuser,   // [0] mode
    // result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] sample_out
    output logic        o_m_axis_tuser    // [0] tail_done
);

    localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int LW = $clog2(MAX_DELAY + 1);
    localparam int CW = (LW > 17) ? LW : 17;

    // ---------------- configuration ----------------
    logic [15:0] r_mix;
    logic [9:0]  r_feedback;
    logic [16:0] r_delay_length;
    logic [15:0] r_quiet_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix          <= fde_pkg::MIX_RESET;
            r_feedback     <= fde_pkg::FB_RESET;
            r_delay_length <= fde_pkg::DELAY_RESET;
            r_quiet_length <= fde_pkg::QUIET_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fde_pkg::REG_MIX:       r_mix          <= i_cfg_data[15:0];
                fde_pkg::REG_FEEDBACK:  r_feedback     <= i_cfg_data[9:0];
                fde_pkg::REG_DELAY_LEN: r_delay_length <= i_cfg_data;
                fde_pkg::REG_QUIET_LEN: r_quiet_length <= i_cfg_data[15:0];
            endcase
        end
    end

    logic [CW-1:0]      dl_ext;
    logic [LW-1:0]      len_eff;
    logic [16:0]        wet;
    logic [16:0]        dry;
    logic [9:0]         fb_eff;

    always_comb begin
        dl_ext = CW'(r_delay_length);
        if (dl_ext == '0) begin
            len_eff = LW'(1);
        end else if (dl_ext > CW'(MAX_DELAY)) begin
            len_eff = LW'(MAX_DELAY);
        end else begin
            len_eff = LW'(dl_ext);
        end
        wet    = ({1'b0, r_mix} > fde_pkg::MIX_ONE) ? fde_pkg::MIX_ONE : {1'b0, r_mix};
        dry    = fde_pkg::MIX_ONE - wet;
        fb_eff = (r_feedback > fde_pkg::FB_LIMIT) ? fde_pkg::FB_LIMIT : r_feedback;
    end

    // ---------------- pipeline registers ----------------
    logic [AW-1:0]      r_line_index;
    logic [LW-1:0]      r_fill;

    logic               r_s1_valid;
    logic               r_s1_mode;
    logic signed [15:0] r_s1_s;
    logic [AW-1:0]      r_s1_idx;
    logic               r_s1_fwd;
    logic signed [15:0] r_s1_fwd_data;
    logic               r_s1_zero;
    logic signed [15:0] r_rdata;

    logic               r_s2_valid;
    logic               r_s2_mode;
    logic signed [15:0] r_s2_s;
    logic signed [15:0] r_s2_d;
    logic [AW-1:0]      r_s2_idx;
    logic               r_s2_neg;
    logic [24:0]        r_s2_p;
    logic signed [31:0] r_s2_m_dry;
    logic signed [31:0] r_s2_m_wet;
    logic               r_s2_quiet;

    logic               r_s3_valid;
    logic               r_s3_mode;
    logic signed [15:0] r_s3_s;
    logic signed [15:0] r_s3_d;
    logic [AW-1:0]      r_s3_idx;
    logic signed [16:0] r_s3_fbq;
    logic signed [31:0] r_s3_acc;
    logic               r_s3_quiet;

    logic [16:0]        r_quiet_cnt;
    logic               r_out_valid;
    logic signed [15:0] r_out_sample;
    logic               r_out_done;

    logic signed [15:0] mem [MAX_DELAY];

    // ---------------- handshake and hazards ----------------
    logic               m1;
    logic               m2;
    logic               m3;
    logic               s_accept;
    logic [AW-1:0]      rd_idx;
    logic [LW-1:0]      nxt_ext;
    logic [AW-1:0]      n_line_index;
    logic               hit1;
    logic               hit2;
    logic               hit3;
    logic               conflict;
    logic               fwd_hit;
    logic signed [15:0] s3_wdata;

    always_comb begin
        rd_idx       = (LW'(r_line_index) >= len_eff) ? '0 : r_line_index;
        nxt_ext      = LW'(rd_idx) + LW'(1);
        n_line_index = (nxt_ext >= len_eff) ? '0 : AW'(nxt_ext);
    end

    assign m3 = r_s3_valid && (!r_out_valid || i_m_axis_tready);
    assign m2 = r_s2_valid && (!r_s3_valid || m3);
    assign m1 = r_s1_valid && (!r_s2_valid || m2);

    assign hit1 = r_s1_valid && (r_s1_idx == rd_idx);
    assign hit2 = r_s2_valid && (r_s2_idx == rd_idx);
    assign hit3 = r_s3_valid && (r_s3_idx == rd_idx);
    // an entry still ahead of its write back holds the read; one being
    // written this cycle is forwarded
    assign conflict = hit1 || hit2 || (hit3 && !m3);
    assign fwd_hit  = hit3 && m3;

    assign o_s_axis_tready = (!r_s1_valid || m1) && !conflict;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // ---------------- stage 0: issue read ----------------
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_rdata <= mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (m3) begin
            mem[r_s3_idx] <= s3_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_index <= '0;
            r_fill       <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (s_accept) begin
                r_line_index <= n_line_index;
                if (LW'(rd_idx) == r_fill) begin
                    r_fill <= r_fill + LW'(1);
                end
                r_s1_valid <= 1'b1;
            end else if (m1) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_mode     <= i_s_axis_tuser;
            r_s1_s        <= i_s_axis_tdata;
            r_s1_idx      <= rd_idx;
            r_s1_fwd      <= fwd_hit;
            r_s1_fwd_data <= s3_wdata;
            r_s1_zero     <= (LW'(rd_idx) >= r_fill);
        end
    end

    // ---------------- stage 1: delayed sample and products ----------------
    logic signed [15:0] d1;
    logic               d1_neg;
    logic [15:0]        d1_mag;
    logic [25:0]        p1;
    logic signed [17:0] wet_s;
    logic signed [17:0] dry_s;
    logic signed [33:0] m_wet;
    logic signed [33:0] m_dry;

    always_comb begin
        if (r_s1_fwd) begin
            d1 = r_s1_fwd_data;
        end else if (r_s1_zero) begin
            d1 = '0;
        end else begin
            d1 = r_rdata;
        end
        d1_neg = d1[15];
        d1_mag = d1_neg ? 16'(-d1) : 16'(d1);
        p1     = {16'd0, fb_eff} * {10'd0, d1_mag};
        wet_s  = $signed({1'b0, wet});
        dry_s  = $signed({1'b0, dry});
        m_wet  = wet_s * d1;
        m_dry  = dry_s * r_s1_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (m1) begin
            r_s2_valid <= 1'b1;
        end else if (m2) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m1) begin
            r_s2_mode  <= r_s1_mode;
            r_s2_s     <= r_s1_s;
            r_s2_d     <= d1;
            r_s2_idx   <= r_s1_idx;
            r_s2_neg   <= d1_neg;
            r_s2_p     <= p1[24:0];
            r_s2_m_dry <= $signed(m_dry[31:0]);
            r_s2_m_wet <= $signed(m_wet[31:0]);
            r_s2_quiet <= (d1 <= fde_pkg::QUIET_LEVEL) && (d1 >= -fde_pkg::QUIET_LEVEL);
        end
    end

    // ---------------- stage 2: divide feedback by 1000, sum mix ----------------
    logic [50:0]        recip_prod;
    logic [15:0]        q2;
    logic signed [16:0] fbq2;

    always_comb begin
        recip_prod = {26'd0, r_s2_p} * {25'd0, fde_pkg::FB_RECIP};
        q2         = recip_prod[50:fde_pkg::FB_RECIP_SHIFT];
        fbq2       = r_s2_neg ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (m2) begin
            r_s3_valid <= 1'b1;
        end else if (m3) begin
            r_s3_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m2) begin
            r_s3_mode  <= r_s2_mode;
            r_s3_s     <= r_s2_s;
            r_s3_d     <= r_s2_d;
            r_s3_idx   <= r_s2_idx;
            r_s3_fbq   <= fbq2;
            r_s3_acc   <= r_s2_m_dry + r_s2_m_wet;
            r_s3_quiet <= r_s2_quiet;
        end
    end

    // ---------------- stage 3: write back and result ----------------
    logic signed [17:0] sum3;
    logic signed [31:0] acc_adj;
    logic signed [16:0] mix3;
    logic signed [15:0] mix_sat;
    logic signed [15:0] res3;
    logic [16:0]        n_quiet_cnt;
    logic               done3;

    always_comb begin
        sum3 = 18'(r_s3_s) + 18'(r_s3_fbq);
        if (sum3 > 18'sd32767) begin
            s3_wdata = 16'sh7FFF;
        end else if (sum3 < -18'sd32768) begin
            s3_wdata = -16'sd32768;
        end else begin
            s3_wdata = sum3[15:0];
        end
        if (r_s3_mode) begin
            s3_wdata = r_s3_fbq[15:0];
        end

        // round toward zero on the divide by 32768
        acc_adj = r_s3_acc + (r_s3_acc[31] ? 32'sd32767 : 32'sd0);
        mix3    = 17'(acc_adj >>> 15);
        if (mix3 > 17'sd32767) begin
            mix_sat = 16'sh7FFF;
        end else if (mix3 < -17'sd32768) begin
            mix_sat = -16'sd32768;
        end else begin
            mix_sat = mix3[15:0];
        end

        if (r_s3_mode) begin
            res3 = r_s3_d;
            if (!r_s3_quiet) begin
                n_quiet_cnt = '0;
            end else if (r_quiet_cnt != fde_pkg::QUIET_MAX) begin
                n_quiet_cnt = r_quiet_cnt + 17'd1;
            end else begin
                n_quiet_cnt = r_quiet_cnt;
            end
            done3 = (n_quiet_cnt >= {1'b0, r_quiet_length});
        end else begin
            res3        = mix_sat;
            n_quiet_cnt = '0;
            done3       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quiet_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (m3) begin
                r_quiet_cnt <= n_quiet_cnt;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (m3) begin
            r_out_sample <= res3;
            r_out_done   <= done3;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_sample;
    assign o_m_axis_tuser  = r_out_done;

    // ---------------- assertions ----------------
    a_no_shared_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_s1_valid && r_s2_valid && r_s1_idx == r_s2_idx) ||
          (r_s2_valid && r_s3_valid && r_s2_idx == r_s3_idx) ||
          (r_s1_valid && r_s3_valid && r_s1_idx == r_s3_idx)))
        else $error("two items in flight on one delay entry");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LW'(MAX_DELAY))
        else $error("fill mark beyond memory depth");

    a_quiet_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m3 && !r_s3_mode) |=> (r_quiet_cnt == '0))
        else $error("quiet count kept after a sample item");

endmodule
